@@ hw/rtl/ordered_record_table_unit_assert.svh @@
// Assertion macros for the ordered record table unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ORDERED_RECORD_TABLE_UNIT_ASSERT_SVH
`define ORDERED_RECORD_TABLE_UNIT_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset.
`define ORT_ASSERT_ALW(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ordered_record_table_unit: invariant violated");

// Check that a trigger implies a condition in the same cycle.
`define ORT_ASSERT_IMP(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("ordered_record_table_unit: implication violated");

`endif

@@ hw/rtl/ortab_pkg.sv @@
// Shared types and constants for the ordered record table unit.
// No dependencies; imported by every module of the block.
package ortab_pkg;

    localparam int POS_W       = 5;
    localparam int KEY_W       = 32;
    localparam int PAY_W       = 32;
    localparam int FIDX_W      = 4;
    localparam int ENTRY_W     = 5;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_DUP  = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] pos;
        logic             pos_over_cap;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } cmd_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } rec_t;

    typedef struct packed {
        status_t           status;
        logic [FIDX_W-1:0] fidx;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
    } res_t;

endpackage

@@ hw/rtl/ortab_front.sv @@
// Front end of the ordered record table: input register and command decode.
// Depends on ortab_pkg; feeds ortab_queue.
module ortab_front
    import ortab_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              opcode,
    input  logic [POS_W-1:0]        position,
    input  logic signed [KEY_W-1:0] record_key,
    input  logic [PAY_W-1:0]        record_payload,
    output logic                    q_push,
    output cmd_t                    q_cmd,
    input  logic                    q_full
);

    logic slot_vld_reg;
    logic slot_vld_next;
    cmd_t slot_reg;
    cmd_t slot_next;
    logic accept;

    assign in_stall = slot_vld_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = slot_vld_reg && !q_full;
    assign q_cmd    = slot_reg;

    // Decode the transaction; the capacity check on position needs no table state
    always_comb
    begin
        slot_next.op           = op_t'(opcode);
        slot_next.pos          = position;
        slot_next.pos_over_cap = 32'(position) > 32'(CAPACITY);
        slot_next.key          = record_key;
        slot_next.payload      = record_payload;
        slot_vld_next          = accept || (slot_vld_reg && q_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= 1'b0;
        end
        else
        begin
            slot_vld_reg <= slot_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

@@ hw/rtl/ortab_queue.sv @@
// Short command queue between the front end and the execution back end.
// Depends on ortab_pkg.
module ortab_queue
    import ortab_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t pop_cmd
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entries [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign full    = fill_reg == FILL_W'(QUEUE_DEPTH);
    assign valid   = fill_reg != '0;
    assign pop_cmd = entries[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/ortab_back.sv @@
// Execution back end: record memory, scan and shift sequencer, result register.
// Depends on ortab_pkg; takes commands from ortab_queue.
module ortab_back
    import ortab_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  cmd_t                      q_cmd,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      success,
    output logic [1:0]                status,
    output logic [FIDX_W-1:0]         found_index,
    output logic signed [KEY_W-1:0]   out_key,
    output logic [PAY_W-1:0]          out_payload,
    output logic [ENTRY_W-1:0]        entry_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_READ  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [CNT_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]   ins_pos_reg, ins_pos_next;
    logic               pend_vld_reg, pend_vld_next;
    logic               dir_up_reg, dir_up_next;
    res_t               res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_res_reg;
    logic [ENTRY_W-1:0] out_count_reg;

    rec_t               mem [CAPACITY];
    rec_t               rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    rec_t               mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;

    logic               out_load;
    logic               table_full;
    logic               q_pos_in;
    logic [CNT_W-1:0]   q_pos_cnt;
    logic               scan_hit;
    logic [CNT_W-1:0]   ins_pos_c;
    logic [CNT_W-1:0]   shift_dst;

    assign table_full = count_reg == CNT_W'(CAPACITY);
    assign q_pos_in   = CMP_W'(q_cmd.pos) < CMP_W'(count_reg);
    assign q_pos_cnt  = CNT_W'(q_cmd.pos);
    assign scan_hit   = pend_vld_reg && (rd_data_reg.key == cmd_reg.key);
    assign ins_pos_c  = (CMP_W'(cmd_reg.pos) > CMP_W'(count_reg)) ? count_reg
                                                                  : CNT_W'(cmd_reg.pos);
    assign shift_dst  = dir_up_reg ? pend_idx_reg + CNT_W'(1) : pend_idx_reg - CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        pend_idx_next  = pend_idx_reg;
        ins_pos_next   = ins_pos_reg;
        pend_vld_next  = pend_vld_reg;
        dir_up_next    = dir_up_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        q_pop          = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    cmd_next      = q_cmd;
                    pend_vld_next = 1'b0;
                    ptr_next      = '0;
                    res_next      = '0;
                    unique case (q_cmd.op)
                        OP_INSERT:
                        begin
                            if (table_full || q_cmd.pos_over_cap)
                            begin
                                res_next.status = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (q_pos_in)
                            begin
                                ptr_next    = q_pos_cnt + CNT_W'(1);
                                left_next   = count_reg - q_pos_cnt - CNT_W'(1);
                                dir_up_next = 1'b0;
                                state_next  = S_SHIFT;
                            end
                            else
                            begin
                                res_next.status = ST_BAD;
                                state_next      = S_DONE;
                            end
                        end
                        OP_FIND:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_READ:
                        begin
                            if (q_pos_in)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = q_pos_cnt[IDX_W-1:0];
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_next.status = ST_BAD;
                                state_next      = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Read one entry a cycle and compare the one read the cycle before
                if (scan_hit)
                begin
                    pend_vld_next = 1'b0;
                    if (cmd_reg.op == OP_INSERT)
                    begin
                        res_next.status = ST_DUP;
                    end
                    else
                    begin
                        res_next.fidx = FIDX_W'(pend_idx_reg);
                    end
                    state_next = S_DONE;
                end
                else if (!pend_vld_reg && (ptr_reg == count_reg))
                begin
                    if (cmd_reg.op == OP_INSERT)
                    begin
                        ins_pos_next = ins_pos_c;
                        left_next    = count_reg - ins_pos_c;
                        ptr_next     = count_reg - CNT_W'(1);
                        dir_up_next  = 1'b1;
                        state_next   = S_SHIFT;
                    end
                    else
                    begin
                        res_next.status = ST_MISS;
                        state_next      = S_DONE;
                    end
                end
                else if (ptr_reg < count_reg)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = ptr_reg[IDX_W-1:0];
                    pend_vld_next = 1'b1;
                    pend_idx_next = ptr_reg;
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    pend_vld_next = 1'b0;
                end
            end

            S_SHIFT:
            begin
                // Write back the entry read last cycle one place over
                if (pend_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = shift_dst[IDX_W-1:0];
                    mem_wdata = rd_data_reg;
                end
                if (left_reg != '0)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = ptr_reg[IDX_W-1:0];
                    pend_vld_next = 1'b1;
                    pend_idx_next = ptr_reg;
                    ptr_next      = dir_up_reg ? ptr_reg - CNT_W'(1) : ptr_reg + CNT_W'(1);
                    left_next     = left_reg - CNT_W'(1);
                end
                else
                begin
                    pend_vld_next = 1'b0;
                    if (!pend_vld_reg)
                    begin
                        if (dir_up_reg)
                        begin
                            mem_we            = 1'b1;
                            mem_waddr         = ins_pos_reg[IDX_W-1:0];
                            mem_wdata.key     = cmd_reg.key;
                            mem_wdata.payload = cmd_reg.payload;
                            count_next        = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        state_next = S_DONE;
                    end
                end
            end

            S_READ:
            begin
                res_next.key     = rd_data_reg.key;
                res_next.payload = rd_data_reg.payload;
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_vld_reg  <= pend_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        ptr_reg      <= ptr_next;
        left_reg     <= left_next;
        pend_idx_reg <= pend_idx_next;
        ins_pos_reg  <= ins_pos_next;
        dir_up_reg   <= dir_up_next;
        res_reg      <= res_next;
        if (out_load)
        begin
            out_res_reg   <= res_reg;
            out_count_reg <= ENTRY_W'(count_reg);
        end
    end

    // Record memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign success     = out_res_reg.status == ST_OK;
    assign status      = out_res_reg.status;
    assign found_index = out_res_reg.fidx;
    assign out_key     = out_res_reg.key;
    assign out_payload = out_res_reg.payload;
    assign entry_count = out_count_reg;

endmodule

@@ hw/rtl/ordered_record_table_unit.sv @@
// Ordered record table unit: top level joining front end, queue and back end.
// Depends on ortab_pkg, ortab_front, ortab_queue, ortab_back and the assert header.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transaction:
//   opcode, position, record_key, record_payload. Output channel
//   (out_valid / out_stall) returns exactly one result per operation, in order:
//   success, status, found_index, out_key, out_payload, entry_count.
//   From acceptance to out_valid an operation passes through the queue, the
//   dispatch step, the work in the back end and the result register.
//   Read does one memory read, find scans up to count entries, delete shifts
//   the entries above position down, insert scans for a duplicate and then
//   shifts the entries from the clamped position up; refused operations do
//   no work. The record memory, one write and one read port, moves one entry
//   per cycle; one operation executes at a time, the next once it is done.
//   The front end keeps accepting into the queue while the back end works.
//   Reset empties the table, the queue and the output register; record
//   contents are left unwritten. When the receiver stalls, the result holds,
//   the back end waits in its final step, and the queue then fills and
//   stalls the input.
`include "ordered_record_table_unit_assert.svh"

module ordered_record_table_unit
    import ortab_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              opcode,
    input  logic [POS_W-1:0]        position,
    input  logic signed [KEY_W-1:0] record_key,
    input  logic [PAY_W-1:0]        record_payload,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    success,
    output logic [1:0]              status,
    output logic [FIDX_W-1:0]       found_index,
    output logic signed [KEY_W-1:0] out_key,
    output logic [PAY_W-1:0]        out_payload,
    output logic [ENTRY_W-1:0]      entry_count
);

    logic fq_push;
    cmd_t fq_cmd;
    logic fq_full;
    logic qb_valid;
    cmd_t qb_cmd;
    logic qb_pop;

    // Register and decode incoming transactions
    ortab_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .position       (position),
        .record_key     (record_key),
        .record_payload (record_payload),
        .q_push         (fq_push),
        .q_cmd          (fq_cmd),
        .q_full         (fq_full)
    );

    // Decouple decode from execution
    ortab_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fq_push),
        .push_cmd (fq_cmd),
        .full     (fq_full),
        .pop      (qb_pop),
        .valid    (qb_valid),
        .pop_cmd  (qb_cmd)
    );

    // Execute against the record memory and hold the result
    ortab_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (qb_valid),
        .q_cmd       (qb_cmd),
        .q_pop       (qb_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .success     (success),
        .status      (status),
        .found_index (found_index),
        .out_key     (out_key),
        .out_payload (out_payload),
        .entry_count (entry_count)
    );

    // Never push into a full queue
    `ORT_ASSERT_ALW(a_queue_no_overflow, !(fq_push && fq_full))
    // Pop only a queue that holds a command
    `ORT_ASSERT_IMP(a_pop_when_valid, qb_pop, qb_valid)
    // A failed operation reports no index and no record
    `ORT_ASSERT_IMP(a_fail_fields_zero, out_valid && !success, {found_index, out_key, out_payload} == '0)
    // The reported count never exceeds the table size
    `ORT_ASSERT_IMP(a_count_bound, out_valid, 32'(entry_count) <= 32'(CAPACITY))

endmodule

@@ sim/tb_ordered_record_table_unit.sv @@
// Self-checking testbench for ordered_record_table_unit.
// Depends on ortab_pkg and the unit's RTL; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module tb_ordered_record_table_unit;
    import ortab_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD    = 400;
    // Longest operation is an insert into a nearly full table: a full duplicate
    // scan and a shift of every entry, plus the pipeline overhead.
    localparam int TAIL_CYCLES  = 2 * TABLE_DEPTH + 30;
    localparam int MAX_REPORTS  = 10;

    // One result transaction, as predicted or as seen on the output ports.
    typedef struct {
        logic                success;
        status_t             status;
        logic [FIDX_W-1:0]   fidx;
        logic [KEY_W-1:0]    key;
        logic [PAY_W-1:0]    payload;
        logic [ENTRY_W-1:0]  count;
    } table_result_t;

    // Shadow copy of the record table. Every accepted input transaction is
    // applied here in order, and the result it should produce is queued.
    class table_tracker;
        logic [KEY_W-1:0] keys [TABLE_DEPTH];
        logic [PAY_W-1:0] payloads [TABLE_DEPTH];
        int               n_records;
        table_result_t    pending_results [$];
        int               error_count;

        function new();
            n_records   = 0;
            error_count = 0;
        endfunction

        function int locate_key(logic [KEY_W-1:0] key);
            for (int i = 0; i < n_records; i++)
                if (keys[i] == key)
                    return i;
            return -1;
        endfunction

        function void apply_op(op_t op, logic [POS_W-1:0] pos, logic [KEY_W-1:0] key,
                               logic [PAY_W-1:0] pay);
            table_result_t r;
            int            slot;
            int            hit;
            r.status  = ST_OK;
            r.fidx    = '0;
            r.key     = '0;
            r.payload = '0;
            case (op)
                OP_INSERT:
                begin
                    if (n_records >= TABLE_DEPTH || pos > TABLE_DEPTH)
                        r.status = ST_BAD;
                    else if (locate_key(key) >= 0)
                        r.status = ST_DUP;
                    else
                    begin
                        // Clamp a position past the end, then open a gap.
                        slot = (pos > n_records) ? n_records : int'(pos);
                        for (int i = n_records; i > slot; i--)
                        begin
                            keys[i]     = keys[i-1];
                            payloads[i] = payloads[i-1];
                        end
                        keys[slot]     = key;
                        payloads[slot] = pay;
                        n_records++;
                    end
                end
                OP_DELETE:
                begin
                    if (pos < n_records)
                    begin
                        for (int i = pos; i + 1 < n_records; i++)
                        begin
                            keys[i]     = keys[i+1];
                            payloads[i] = payloads[i+1];
                        end
                        n_records--;
                    end
                    else
                        r.status = ST_BAD;
                end
                OP_FIND:
                begin
                    hit = locate_key(key);
                    if (hit >= 0)
                        r.fidx = hit[FIDX_W-1:0];
                    else
                        r.status = ST_MISS;
                end
                default:
                begin
                    if (pos < n_records)
                    begin
                        r.key     = keys[pos];
                        r.payload = payloads[pos];
                    end
                    else
                        r.status = ST_BAD;
                end
            endcase
            r.success = (r.status == ST_OK);
            r.count   = ENTRY_W'(n_records);
            pending_results.push_back(r);
        endfunction

        function void match_result(table_result_t got);
            table_result_t want;
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result arrived with nothing outstanding", $realtime);
                return;
            end
            want = pending_results.pop_front();
            if (want.success !== got.success || want.status !== got.status ||
                want.fidx !== got.fidx || want.key !== got.key ||
                want.payload !== got.payload || want.count !== got.count)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected ok=%0b st=%0d idx=%0d key=%h pay=%h n=%0d",
                             want.success, want.status, want.fidx, want.key,
                             want.payload, want.count);
                    $display("  actual   ok=%0b st=%0d idx=%0d key=%h pay=%h n=%0d",
                             got.success, got.status, got.fidx, got.key,
                             got.payload, got.count);
                end
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              opcode;
    logic [POS_W-1:0]        position;
    logic signed [KEY_W-1:0] record_key;
    logic [PAY_W-1:0]        record_payload;
    logic                    out_valid;
    logic                    out_stall;
    logic                    success;
    logic [1:0]              status;
    logic [FIDX_W-1:0]       found_index;
    logic signed [KEY_W-1:0] out_key;
    logic [PAY_W-1:0]        out_payload;
    logic [ENTRY_W-1:0]      entry_count;

    table_tracker tracker;
    // Raised by the sender to ask the receiver for one long hold-off.
    bit           hold_req;
    bit           filling;

    ordered_record_table_unit #(
        .CAPACITY (TABLE_DEPTH)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .position       (position),
        .record_key     (record_key),
        .record_payload (record_payload),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .success        (success),
        .status         (status),
        .found_index    (found_index),
        .out_key        (out_key),
        .out_payload    (out_payload),
        .entry_count    (entry_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Offer one transaction at the falling edge and hold it until accepted.
    // The shadow table is updated at the accepting edge, so the next
    // transaction can be shaped from the up-to-date contents.
    task automatic send_op(op_t op, logic [POS_W-1:0] pos, logic [KEY_W-1:0] key,
                           logic [PAY_W-1:0] pay);
        @(negedge clk);
        in_valid       = 1'b1;
        opcode         = op;
        position       = pos;
        record_key     = key;
        record_payload = pay;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.apply_op(op, pos, key, pay);
    endtask

    // Drop valid for a number of cycles; the payload lines carry noise meanwhile.
    task automatic idle_input(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid       = 1'b0;
            opcode         = 2'($urandom_range(0, 3));
            record_key     = $urandom;
            record_payload = $urandom;
        end
    endtask

    // Hold the input idle until every queued expectation has been met.
    task automatic drain_results();
        idle_input(1);
        while (tracker.pending_results.size() > 0)
            @(posedge clk);
    endtask

    // Keys: often one already in the table (duplicates and find hits), some
    // corner values, the rest fully random.
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && tracker.n_records > 0)
            return tracker.keys[$urandom_range(0, tracker.n_records - 1)];
        if (sel < 6)
        begin
            case ($urandom_range(0, 4))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h8000_0000;
                3:       return 32'h7FFF_FFFF;
                default: return KEY_W'($urandom_range(1, 8));
            endcase
        end
        return $urandom;
    endfunction

    // Alternate between filling and draining so that both a full and an
    // empty table come round many times.
    function automatic op_t pick_op();
        int roll;
        if (tracker.n_records == 0)
            filling = 1'b1;
        else if (tracker.n_records == TABLE_DEPTH && $urandom_range(0, 3) == 0)
            filling = 1'b0;
        else if ($urandom_range(0, 39) == 0)
            filling = ~filling;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return OP_FIND;
        if (roll < 40)
            return OP_READ;
        if (filling)
            return (roll < 88) ? OP_INSERT : OP_DELETE;
        return (roll < 52) ? OP_INSERT : OP_DELETE;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(op_t op);
        int roll;
        int n;
        roll = $urandom_range(0, 19);
        n    = tracker.n_records;
        if (roll == 0)
            return POS_W'($urandom_range(TABLE_DEPTH + 1, 31));
        if (roll < 4)
            return POS_W'($urandom_range(0, TABLE_DEPTH));
        if (op == OP_INSERT || n == 0)
            return POS_W'($urandom_range(0, n));
        return POS_W'($urandom_range(0, n - 1));
    endfunction

    task automatic send_random_op();
        op_t op;
        if ($urandom_range(0, 19) == 0)
        begin
            // Noise: anything the ports allow.
            send_op(op_t'($urandom_range(0, 3)), POS_W'($urandom_range(0, 31)),
                    $urandom, $urandom);
        end
        else
        begin
            op = pick_op();
            send_op(op, pick_pos(op), pick_key(), $urandom);
        end
    endtask

    // Receiver: stretches of random stall density, including stretches of no
    // stall, plus one long hold-off on request to back the block up.
    initial
    begin
        int seg_left;
        int mode;
        bit hold_taken;
        out_stall  = 1'b0;
        seg_left   = 0;
        mode       = 0;
        hold_taken = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_stall  = 1'b1;
                repeat (LONG_HOLD - 1)
                    @(negedge clk);
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(8, 64);
                end
                seg_left--;
                case (mode)
                    0:       out_stall = 1'b0;
                    1:       out_stall = ($urandom_range(0, 99) < 30);
                    default: out_stall = ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    // Sample the output channel at the rising edge and check each accepted
    // result against the oldest prediction.
    always @(posedge clk)
    begin : result_monitor
        table_result_t seen;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.success = success;
            seen.status  = status_t'(status);
            seen.fidx    = found_index;
            seen.key     = out_key;
            seen.payload = out_payload;
            seen.count   = entry_count;
            tracker.match_result(seen);
        end
    end

    initial
    begin
        int               sent;
        int               burst;
        bit               hold_done;
        bit               pause_done;
        logic [POS_W-1:0] fill_pos;
        tracker        = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_INSERT;
        position       = '0;
        record_key     = '0;
        record_payload = '0;
        hold_req       = 1'b0;
        filling        = 1'b1;
        hold_done      = 1'b0;
        pause_done     = 1'b0;
        sent           = 0;

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        idle_input(2);

        // Directed: every operation on an empty table first.
        send_op(OP_READ,   5'd0,  32'h0000_0000, 32'h0000_0000);
        send_op(OP_DELETE, 5'd0,  32'h0000_0000, 32'h0000_0000);
        send_op(OP_FIND,   5'd0,  32'h1234_5678, 32'h0000_0000);
        // Key and payload extremes; a position past the end is appended.
        send_op(OP_INSERT, 5'd0,  32'h8000_0000, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 5'd16, 32'h7FFF_FFFF, 32'h0000_0000);
        // Position beyond capacity, then a duplicate key.
        send_op(OP_INSERT, 5'd31, 32'h0000_0001, 32'h5555_5555);
        send_op(OP_INSERT, 5'd0,  32'h8000_0000, 32'hAAAA_AAAA);
        send_op(OP_FIND,   5'd0,  32'h7FFF_FFFF, 32'h0000_0000);
        send_op(OP_READ,   5'd1,  32'h0000_0000, 32'h0000_0000);
        // Fill to capacity at the head, the tail and the middle.
        for (int i = 0; i < TABLE_DEPTH - 2; i++)
        begin
            case (i % 3)
                0:       fill_pos = 5'd0;
                1:       fill_pos = 5'd16;
                default: fill_pos = POS_W'(tracker.n_records / 2);
            endcase
            send_op(OP_INSERT, fill_pos, 32'h1000_0000 + i * 32'h0101_0101, $urandom);
        end
        // Full table: insert refused, top index found and read, delete beyond
        // the end refused, then a delete that shifts every entry down.
        send_op(OP_INSERT, 5'd3,  32'h0BAD_F00D, 32'h1111_1111);
        send_op(OP_FIND,   5'd0,  tracker.keys[TABLE_DEPTH-1], 32'h0000_0000);
        send_op(OP_READ,   5'd15, 32'h0000_0000, 32'h0000_0000);
        send_op(OP_DELETE, 5'd16, 32'h0000_0000, 32'h0000_0000);
        send_op(OP_DELETE, 5'd0,  32'h0000_0000, 32'h0000_0000);
        drain_results();

        // Random bursts with random gaps; some bursts run back to back.
        while (sent < RANDOM_ITEMS)
        begin
            if (!hold_done && sent >= RANDOM_ITEMS / 3)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && sent >= (2 * RANDOM_ITEMS) / 3)
            begin
                drain_results();
                pause_done = 1'b1;
            end
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                send_random_op();
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_input($urandom_range(1, 8));
        end

        drain_results();
        // Catch any stray result after the last expected one.
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (tracker.error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run.
    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule
